// ===== sv/gtq_pkg.sv =====
// gtq_pkg: shared types and codes of the grouped team queue
// no dependencies; compiled first
`default_nettype none

package gtq_pkg;

    // fixed field widths of the request and response channels
    localparam int KIND_W   = 1;
    localparam int GROUP_W  = 2;
    localparam int MEMBER_W = 16;
    localparam int STATUS_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic latch;  // capture the accepted request
        logic look;   // select group, read its pointers
        logic exec;   // update state, access member store
        logic load;   // move the result into the output register
    } gtq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;  // output register holds a result that is not taken
    } gtq_sts_t;

endpackage

`default_nettype wire

// ===== sv/gtq_req_if.sv =====
// gtq_req_if: request channel of the grouped team queue
// depends on gtq_pkg for field widths
`default_nettype none

interface gtq_req_if
    import gtq_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [GROUP_W-1:0]  group;
    logic [MEMBER_W-1:0] member_id;

    modport source (output valid, kind, group, member_id, input ready);
    modport sink   (input valid, kind, group, member_id, output ready);
endinterface

`default_nettype wire

// ===== sv/gtq_rsp_if.sv =====
// gtq_rsp_if: response channel of the grouped team queue
// depends on gtq_pkg for field widths
`default_nettype none

interface gtq_rsp_if
    import gtq_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GROUP_W-1:0]  out_group;
    logic [MEMBER_W-1:0] out_member_id;

    modport source (output valid, status, out_group, out_member_id, input ready);
    modport sink   (input valid, status, out_group, out_member_id, output ready);
endinterface

`default_nettype wire

// ===== sv/grouped_team_queue.sv =====
// A request is captured, its group looked up, the queue state updated and the
// single-port member store accessed, then the result moves to the output register;
// the load waits while the output register holds a result that is not taken.
// The next request is taken in the cycle the response is loaded.
// Reset (async, active low) clears group pointers, fill counts, order ring
// pointers and the sequencer; member store and order ring contents are not cleared.
`default_nettype none

module grouped_team_queue
    import gtq_pkg::*;
#(
    parameter int GROUPS      = 4,
    parameter int GROUP_DEPTH = 1024,
    parameter int ID_BITS     = 16
)
(
    input wire logic  clk,
    input wire logic  rst_n,
    gtq_req_if.sink   req,
    gtq_rsp_if.source rsp
);

    gtq_cmd_t cmd;
    gtq_sts_t sts;

    // sequencer
    gtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // queue state and member store
    gtq_dpath #(
        .GROUPS      (GROUPS),
        .GROUP_DEPTH (GROUP_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_kind      (req.kind),
        .req_group     (req.group),
        .req_member_id (req.member_id),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_group     (rsp.out_group),
        .rsp_member_id (rsp.out_member_id)
    );

endmodule

`default_nettype wire

// ===== sv/gtq_ctrl.sv =====
// gtq_ctrl: sequencing state machine of the grouped team queue
// depends on gtq_pkg for command and status structs
`default_nettype none

module gtq_ctrl
    import gtq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire gtq_sts_t sts,
    output gtq_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hand off the result, take the next request in the same cycle
                if (!sts.out_busy)
                begin
                    cmd.load  = 1'b1;
                    req_ready = 1'b1;
                    if (req_valid)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gtq_dpath.sv =====
// gtq_dpath: group pointers, order ring, member store and output register
// depends on gtq_pkg for codes and command and status structs
`default_nettype none

module gtq_dpath
    import gtq_pkg::*;
#(
    parameter int GROUPS      = 4,
    parameter int GROUP_DEPTH = 1024,
    parameter int ID_BITS     = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gtq_cmd_t            cmd,
    output gtq_sts_t                 sts,
    input  wire logic [KIND_W-1:0]   req_kind,
    input  wire logic [GROUP_W-1:0]  req_group,
    input  wire logic [MEMBER_W-1:0] req_member_id,
    input  wire logic                rsp_ready,
    output logic                     rsp_valid,
    output logic [STATUS_W-1:0]      rsp_status,
    output logic [GROUP_W-1:0]       rsp_group,
    output logic [MEMBER_W-1:0]      rsp_member_id
);

    localparam int GW  = $clog2(GROUPS);
    localparam int HW  = $clog2(GROUP_DEPTH);
    localparam int CW  = $clog2(GROUP_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int OCW = $clog2(GROUPS + 1);
    localparam int TW  = OCW + 1;
    localparam int AW  = $clog2(GROUPS * GROUP_DEPTH);
    localparam int MEM_DEPTH = GROUPS * GROUP_DEPTH;

    // captured request
    logic [KIND_W-1:0]  kind_reg;
    logic [GROUP_W-1:0] grp_in_reg;
    logic [ID_BITS-1:0] id_reg;

    // per-group ring pointers and fill counts
    logic [HW-1:0] group_head_reg  [GROUPS];
    logic [CW-1:0] group_count_reg [GROUPS];

    // ring of groups that hold members
    logic [GW-1:0]  order_ring_reg [GROUPS];
    logic [GW-1:0]  order_head_reg;
    logic [OCW-1:0] order_count_reg;

    // values looked up for the selected group
    logic [GW-1:0] g_reg;
    logic [HW-1:0] head_reg;
    logic [CW-1:0] cnt_reg;
    logic          grp_bad_reg;
    logic          oempty_reg;

    // result of the operation
    logic [STATUS_W-1:0] status_reg;
    logic [ID_BITS-1:0]  rd_data_reg;

    // output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GROUP_W-1:0]  out_group_reg;
    logic [MEMBER_W-1:0] out_member_reg;

    // member store
    logic [ID_BITS-1:0] mem [MEM_DEPTH];

    logic [GW-1:0]       sel_g;
    logic                enq_ok;
    logic                deq_ok;
    logic                deq_stale;
    logic                order_push;
    logic                order_pop;
    logic [SW-1:0]       slot_sum;
    logic [SW-1:0]       slot_wrap;
    logic [HW-1:0]       slot;
    logic [AW-1:0]       addr;
    logic [HW-1:0]       head_inc;
    logic [TW-1:0]       tail_sum;
    logic [TW-1:0]       tail_wrap;
    logic [GW-1:0]       order_tail;
    logic [GW-1:0]       order_head_inc;
    logic [STATUS_W-1:0] status_next;

    // group selection for the lookup cycle
    assign sel_g = (kind_reg == KIND_DEQ) ? order_ring_reg[order_head_reg]
                                          : GW'(grp_in_reg);

    // operation decode from the looked-up values
    always_comb
    begin
        enq_ok    = (kind_reg == KIND_ENQ) && !grp_bad_reg
                    && (cnt_reg != CW'(GROUP_DEPTH));
        deq_ok    = (kind_reg == KIND_DEQ) && !oempty_reg && (cnt_reg != '0);
        deq_stale = (kind_reg == KIND_DEQ) && !oempty_reg && (cnt_reg == '0);
        order_push = enq_ok && (cnt_reg == '0) && (order_count_reg < OCW'(GROUPS));
        order_pop  = deq_stale || (deq_ok && (cnt_reg == CW'(1)));
        if (kind_reg == KIND_ENQ)
        begin
            status_next = enq_ok ? ST_ENQ : ST_FULL;
        end
        else
        begin
            status_next = deq_ok ? ST_DEQ : ST_EMPTY;
        end
    end

    // member store address: tail slot for enqueue, head slot for dequeue
    always_comb
    begin
        slot_sum  = SW'(head_reg) + SW'(cnt_reg);
        slot_wrap = (slot_sum >= SW'(GROUP_DEPTH)) ? slot_sum - SW'(GROUP_DEPTH) : slot_sum;
        slot      = (kind_reg == KIND_ENQ) ? slot_wrap[HW-1:0] : head_reg;
        addr      = AW'(g_reg) * AW'(GROUP_DEPTH) + AW'(slot);
        head_inc  = (head_reg == HW'(GROUP_DEPTH - 1)) ? '0 : head_reg + HW'(1);
    end

    // order ring tail and head advance
    always_comb
    begin
        tail_sum  = TW'(order_head_reg) + TW'(order_count_reg);
        tail_wrap = (tail_sum >= TW'(GROUPS)) ? tail_sum - TW'(GROUPS) : tail_sum;
        order_tail = tail_wrap[GW-1:0];
        order_head_inc = (order_head_reg == GW'(GROUPS - 1)) ? '0
                                                              : order_head_reg + GW'(1);
    end

    // request capture, lookup and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg   <= req_kind;
            grp_in_reg <= req_group;
            id_reg     <= ID_BITS'(req_member_id);
        end
        if (cmd.look)
        begin
            g_reg       <= sel_g;
            head_reg    <= group_head_reg[sel_g];
            cnt_reg     <= group_count_reg[sel_g];
            grp_bad_reg <= (kind_reg == KIND_ENQ) && (32'(grp_in_reg) >= 32'(GROUPS));
            oempty_reg  <= (order_count_reg == '0);
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
        end
        if (order_push && cmd.exec)
        begin
            order_ring_reg[order_tail] <= g_reg;
        end
    end

    // member store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq_ok)
        begin
            mem[addr] <= id_reg;
        end
        if (cmd.exec && deq_ok)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // group pointers and order ring control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                group_head_reg[i]  <= '0;
                group_count_reg[i] <= '0;
            end
            order_head_reg  <= '0;
            order_count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            if (enq_ok)
            begin
                group_count_reg[g_reg] <= cnt_reg + CW'(1);
            end
            if (deq_ok)
            begin
                group_head_reg[g_reg]  <= head_inc;
                group_count_reg[g_reg] <= cnt_reg - CW'(1);
            end
            if (order_push)
            begin
                order_count_reg <= order_count_reg + OCW'(1);
            end
            if (order_pop)
            begin
                order_head_reg  <= order_head_inc;
                order_count_reg <= order_count_reg - OCW'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            if (status_reg == ST_DEQ)
            begin
                out_group_reg  <= GROUP_W'(g_reg);
                out_member_reg <= MEMBER_W'(rd_data_reg);
            end
            else
            begin
                out_group_reg  <= '0;
                out_member_reg <= '0;
            end
        end
    end

    assign sts.out_busy  = out_valid_reg && !rsp_ready;
    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_group     = out_group_reg;
    assign rsp_member_id = out_member_reg;

endmodule

`default_nettype wire

// ===== sv/gtq_checker.sv =====
// gtq_checker: port-level assertions for the grouped team queue
// depends on gtq_pkg for status codes; bound to grouped_team_queue below
`default_nettype none

module gtq_checker
    import gtq_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] rsp_status,
    input wire logic [GROUP_W-1:0]  rsp_group,
    input wire logic [MEMBER_W-1:0] rsp_member_id
);

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_group) && $stable(rsp_member_id))
        else $error("response changed while stalled");

    // only a dequeue response carries a group and member id
    a_rsp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_DEQ) |-> (rsp_group == '0) && (rsp_member_id == '0))
        else $error("non-dequeue response with nonzero payload");

    // an accepted request occupies the block in the following cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_group     (rsp.out_group),
    .rsp_member_id (rsp.out_member_id)
);

`default_nettype wire
